### rtl/mts_pkg.sv
`timescale 1ns / 1ps

package mts_pkg;

  // Operation codes carried on in_func.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Shift control broadcast from the controller to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } mts_shift_t;

endpackage

### rtl/mts_cell.sv
`timescale 1ns / 1ps

module mts_cell #(
  parameter int ENTRY_WIDTH = 18
) (
  input  logic                    clk,
  input  mts_pkg::mts_shift_t     shift,
  input  logic [ENTRY_WIDTH-1:0]  upper_in,
  input  logic [ENTRY_WIDTH-1:0]  lower_in,
  output logic [ENTRY_WIDTH-1:0]  entry
);
  import mts_pkg::*;

  logic [ENTRY_WIDTH-1:0] entry_r;

  // A push moves every entry one cell away from the top; a pop pulls them back.
  always_ff @(posedge clk) begin
    if (shift.push) begin
      entry_r <= upper_in;
    end else if (shift.pop) begin
      entry_r <= lower_in;
    end
  end

  assign entry = entry_r;

endmodule

### rtl/min_tracking_stack_unit.sv
`timescale 1ns / 1ps

// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+---------------------------
// request   | in_func, in_value                             | start high while busy low
// result    | out_top_value, out_min_value, out_entry_count,| out_valid for one cycle,
//           | out_is_empty, out_rejected                    | no back pressure
//
// For each request taken and not rejected, the cells shift and the minimum register updates
// at the accepting edge, and the result is shown in the following cycle while busy is high.
// The top of stack always sits in cell 0, so neither a push nor a pop waits on a read.
// Reset (rst_n low, synchronous) clears the entry count, the minimum and the strobe;
// the cell contents stay undefined until pushed. The receiver cannot stall the unit.

module min_tracking_stack_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_func,
  input  logic signed [VALUE_WIDTH-1:0]        in_value,
  output logic                                 out_valid,
  output logic signed [VALUE_WIDTH-1:0]        out_top_value,
  output logic signed [VALUE_WIDTH-1:0]        out_min_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     out_entry_count,
  output logic                                 out_is_empty,
  output logic                                 out_rejected
);
  import mts_pkg::*;

  localparam int EW    = VALUE_WIDTH + 2;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic signed [VALUE_WIDTH-1:0] min_r, min_nxt;
  logic                          busy_r, out_valid_r, rejected_r;

  logic                  accept, do_push, do_pop, is_full, is_empty;
  logic signed [EW-1:0]  value_ext, min_ext, top_entry, push_entry, restored_min;
  logic                  value_below, top_below;
  mts_shift_t            shift;
  logic [EW-1:0]         cell_q [STACK_DEPTH];

  assign accept   = start && !busy_r;
  assign is_full  = (count_r == CNT_W'(STACK_DEPTH));
  assign is_empty = (count_r == '0);
  assign do_push  = accept && (in_func == FUNC_PUSH) && !is_full;
  assign do_pop   = accept && (in_func == FUNC_POP) && !is_empty;

  assign value_ext   = EW'(in_value);
  assign min_ext     = EW'(min_r);
  assign top_entry   = $signed(cell_q[0]);
  assign value_below = (value_ext < min_ext);
  assign top_below   = (top_entry < min_ext);

  // Encoded entries are two bits wider than values, so neither form can overflow.
  assign restored_min = (min_ext <<< 1) - top_entry;

  always_comb begin
    push_entry = value_ext;
    if (!is_empty && value_below) begin
      push_entry = (value_ext <<< 1) - min_ext;
    end
  end

  always_comb begin
    min_nxt   = min_r;
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CNT_W'(1);
      if (is_empty || value_below) begin
        min_nxt = in_value;
      end
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
      if (top_below) begin
        min_nxt = restored_min[VALUE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      min_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rejected_r  <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      busy_r      <= accept;
      out_valid_r <= accept;
      if (accept) begin
        rejected_r <= !(do_push || do_pop);
      end
    end
  end

  assign shift.push = do_push;
  assign shift.pop  = do_pop;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [EW-1:0] upper_d, lower_d;
    if (i == 0) begin : g_head
      assign upper_d = push_entry;
    end else begin : g_body
      assign upper_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign lower_d = cell_q[i];
    end else begin : g_link
      assign lower_d = cell_q[i+1];
    end
    mts_cell #(
      .ENTRY_WIDTH(EW)
    ) u_cell (
      .clk      (clk),
      .shift    (shift),
      .upper_in (upper_d),
      .lower_in (lower_d),
      .entry    (cell_q[i])
    );
  end

  // Results are decoded from the state left by the request just taken.
  always_comb begin
    out_top_value = '0;
    out_min_value = '0;
    if (!is_empty) begin
      out_min_value = min_r;
      out_top_value = top_below ? min_r : top_entry[VALUE_WIDTH-1:0];
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_entry_count = count_r;
  assign out_is_empty    = is_empty;
  assign out_rejected    = rejected_r;

endmodule

### rtl/mts_checker.sv
`timescale 1ns / 1ps

module mts_checker #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic signed [VALUE_WIDTH-1:0]     out_top_value,
  input logic signed [VALUE_WIDTH-1:0]     out_min_value,
  input logic [$clog2(STACK_DEPTH+1)-1:0]  out_entry_count,
  input logic                              out_is_empty
);

  // Every accepted request produces exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted request gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start) && !$past(busy)))
    else $error("result without an accepted request");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_top_value == '0 && out_min_value == '0))
    else $error("empty stack shows a nonzero value");

  // The minimum can never exceed the value on top of the stack.
  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_empty) |-> (out_top_value >= out_min_value))
    else $error("minimum above top value");

endmodule

bind min_tracking_stack_unit mts_checker #(
  .STACK_DEPTH(STACK_DEPTH),
  .VALUE_WIDTH(VALUE_WIDTH)
) u_mts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_top_value   (out_top_value),
  .out_min_value   (out_min_value),
  .out_entry_count (out_entry_count),
  .out_is_empty    (out_is_empty)
);
